### rtl/core/ecc_pkg.sv
// Shared types and constants for the environmental sensor compensation core.
package ecc_pkg;

    localparam int DIV_W = 64;

    localparam logic [2:0] REG_TEMP       = 3'd0;
    localparam logic [2:0] REG_PRESS_LOW  = 3'd1;
    localparam logic [2:0] REG_PRESS_HIGH = 3'd2;
    localparam logic [2:0] REG_MIXED      = 3'd3;
    localparam logic [2:0] REG_HUM        = 3'd4;

    localparam logic [16:0] HUM_MAX = 17'd102400;

    typedef struct packed {
        logic        [15:0] t1;
        logic signed [15:0] t2;
        logic signed [15:0] t3;
        logic        [15:0] p1;
        logic signed [15:0] p2;
        logic signed [15:0] p3;
        logic signed [15:0] p4;
        logic signed [15:0] p5;
        logic signed [15:0] p6;
        logic signed [15:0] p7;
        logic signed [15:0] p8;
        logic signed [15:0] p9;
        logic        [7:0]  h1;
        logic signed [15:0] h2;
        logic        [7:0]  h3;
        logic signed [15:0] h4;
        logic signed [15:0] h5;
        logic signed [7:0]  h6;
    } coef_t;

    // fields that ride alongside the divider
    typedef struct packed {
        logic [31:0] temp;
        logic [16:0] hum;
        logic        inv;
        logic        qneg;
    } side_t;

    typedef struct packed {
        logic [31:0] temp;
        logic [31:0] press;
        logic        inv;
        logic [16:0] hum;
    } res_t;

endpackage

### rtl/core/env_sensor_compensation_core.sv
// Top level of the environmental sensor compensation core.
//
// One raw sample (temperature, pressure, humidity readings) enters on the
// s_ stream per transfer; one compensated result leaves on the m_ stream.
// s_tdata: raw_temperature [19:0], raw_pressure [39:20], raw_humidity [55:40].
// m_tdata: temperature_centi [31:0], pressure_q24_8 [63:32],
//          humidity_q7_10 [80:64], zero fill above. m_tuser: pressure_invalid.
// Calibration is loaded through cfg_we/cfg_addr/cfg_wdata, one register a
// write. The user must write it only while no sample is in flight;
// the block does not enforce this. Unknown addresses are ignored.
// Throughput: one sample per cycle unless the output stalls. Stages: 11 front,
// 64 divider (one quotient bit each), 5 back ending in the output register.
// The whole pipeline advances together; when m_tvalid is high and m_tready
// is low every stage holds and s_tready drops, so nothing is lost.
// Reset (aresetn low, synchronous) empties the pipeline and clears all
// calibration registers to zero.
module env_sensor_compensation_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // raw_temperature, raw_pressure, raw_humidity
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [87:0] m_tdata,   // temperature_centi, pressure_q24_8, humidity_q7_10
    output logic [0:0]  m_tuser,   // pressure_invalid
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [63:0] cfg_wdata
);
    import ecc_pkg::*;

    logic [47:0] temp_coeffs_reg;
    logic [63:0] press_low_reg;
    logic [63:0] press_high_reg;
    logic [47:0] mixed_coeffs_reg;
    logic [39:0] hum_coeffs_reg;

    coef_t       coef;
    logic        en;
    logic        f_vld, d_vld, b_vld;
    logic [63:0] f_num, f_den, d_quot;
    side_t       f_side, d_side;
    res_t        res;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            temp_coeffs_reg  <= '0;
            press_low_reg    <= '0;
            press_high_reg   <= '0;
            mixed_coeffs_reg <= '0;
            hum_coeffs_reg   <= '0;
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_TEMP:       temp_coeffs_reg  <= cfg_wdata[47:0];
                REG_PRESS_LOW:  press_low_reg    <= cfg_wdata;
                REG_PRESS_HIGH: press_high_reg   <= cfg_wdata;
                REG_MIXED:      mixed_coeffs_reg <= cfg_wdata[47:0];
                REG_HUM:        hum_coeffs_reg   <= cfg_wdata[39:0];
                default: begin
                end
            endcase
        end
    end

    assign coef.t1 = temp_coeffs_reg[15:0];
    assign coef.t2 = temp_coeffs_reg[31:16];
    assign coef.t3 = temp_coeffs_reg[47:32];
    assign coef.p1 = press_low_reg[15:0];
    assign coef.p2 = press_low_reg[31:16];
    assign coef.p3 = press_low_reg[47:32];
    assign coef.p4 = press_low_reg[63:48];
    assign coef.p5 = press_high_reg[15:0];
    assign coef.p6 = press_high_reg[31:16];
    assign coef.p7 = press_high_reg[47:32];
    assign coef.p8 = press_high_reg[63:48];
    assign coef.p9 = mixed_coeffs_reg[15:0];
    assign coef.h1 = mixed_coeffs_reg[23:16];
    assign coef.h2 = mixed_coeffs_reg[39:24];
    assign coef.h3 = mixed_coeffs_reg[47:40];
    assign coef.h4 = hum_coeffs_reg[15:0];
    assign coef.h5 = hum_coeffs_reg[31:16];
    assign coef.h6 = hum_coeffs_reg[39:32];

    // global advance: hold everything while the output transfer is pending
    assign en       = !b_vld || m_tready;
    assign s_tready = en;

    ecc_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_vld   (s_tvalid),
        .in_t     (s_tdata[19:0]),
        .in_p     (s_tdata[39:20]),
        .in_h     (s_tdata[55:40]),
        .c        (coef),
        .out_vld  (f_vld),
        .out_num  (f_num),
        .out_den  (f_den),
        .out_side (f_side)
    );

    ecc_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_vld   (f_vld),
        .in_num   (f_num),
        .in_den   (f_den),
        .in_side  (f_side),
        .out_vld  (d_vld),
        .out_quot (d_quot),
        .out_side (d_side)
    );

    ecc_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .in_vld  (d_vld),
        .in_quot (d_quot),
        .in_side (d_side),
        .c       (coef),
        .out_vld (b_vld),
        .out_res (res)
    );

    assign m_tvalid = b_vld;
    assign m_tdata  = {7'd0, res.hum, res.press, res.temp};
    assign m_tuser  = res.inv;

`ifndef SYNTH
    a_inv_press_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> (m_tdata[63:32] == 32'd0))
        else $error("invalid pressure result carries a nonzero value");

    a_hum_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[80:64] <= HUM_MAX))
        else $error("humidity above full scale");

    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("input stalled without output backpressure");

    a_hold_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("result changed while stalled");
`endif

endmodule

### rtl/core/ecc_front.sv
// Front pipeline: temperature, humidity and pressure up to the divider operands.
module ecc_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 en,
    input  logic                 in_vld,
    input  logic [19:0]          in_t,
    input  logic [19:0]          in_p,
    input  logic [15:0]          in_h,
    input  ecc_pkg::coef_t       c,
    output logic                 out_vld,
    output logic [63:0]          out_num,
    output logic [63:0]          out_den,
    output ecc_pkg::side_t       out_side
);
    import ecc_pkg::*;

    logic [10:0] vld_reg;

    // stage 1
    logic signed [31:0] d1, d2;
    logic signed [31:0] s1_tap_reg, s1_sq_reg;
    logic [19:0] s1_adcp_reg;
    logic [15:0] s1_adch_reg;
    // stage 2
    logic signed [31:0] s2_ta_reg, s2_m2_reg;
    logic [19:0] s2_adcp_reg;
    logic [15:0] s2_adch_reg;
    // stage 3
    logic signed [31:0] s3_tfine_reg;
    logic [19:0] s3_adcp_reg;
    logic [15:0] s3_adch_reg;
    // stage 4
    logic signed [31:0] t5;
    logic signed [31:0] s4_temp_reg, s4_v_reg;
    logic signed [63:0] s4_a_reg;
    logic [19:0] s4_adcp_reg;
    logic [15:0] s4_adch_reg;
    // stage 5
    logic signed [32:0] a33;
    logic signed [65:0] aa_full;
    logic signed [63:0] s5_aa_reg, s5_ap5_reg, s5_ap2_reg;
    logic signed [31:0] s5_h5v_reg, s5_vh6_reg, s5_vh3_reg, s5_temp_reg;
    logic [19:0] s5_adcp_reg;
    logic [15:0] s5_adch_reg;
    // stage 6
    logic signed [63:0] s6_b1_reg, s6_aa3_reg, s6_ap5_reg, s6_ap2_reg;
    logic signed [31:0] s6_ha_reg, s6_hb1_reg, s6_temp_reg;
    logic [19:0] s6_adcp_reg;
    // stage 7
    logic signed [63:0] s7_b_reg, s7_a2_reg;
    logic signed [31:0] s7_hb2_reg, s7_ha_reg, s7_temp_reg;
    logic [19:0] s7_adcp_reg;
    // stage 8
    logic signed [63:0] s8_a3_reg, s8_b_reg;
    logic signed [31:0] s8_hv_reg, s8_temp_reg;
    logic [19:0] s8_adcp_reg;
    // stage 9
    logic [20:0] pdiff;
    logic signed [63:0] s9_dv_reg, s9_pn_reg;
    logic signed [31:0] s9_ss_reg, s9_hv_reg, s9_temp_reg;
    // stage 10
    logic signed [63:0] s10_num_reg, s10_dv_reg;
    logic signed [31:0] s10_k_reg, s10_hv_reg, s10_temp_reg;
    // stage 11
    logic signed [31:0] v2;
    logic [16:0] hum_next;
    logic [63:0] num_next, den_next;
    logic inv_next;
    logic [63:0] num_reg, den_reg;
    side_t side_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[9:0], in_vld};
        end
    end

    assign d1 = $signed({15'd0, in_t[19:3]}) - $signed({15'd0, c.t1, 1'b0});
    assign d2 = $signed({16'd0, in_t[19:4]}) - $signed({16'd0, c.t1});

    assign t5 = s3_tfine_reg + (s3_tfine_reg <<< 2) + 32'sd128;

    // a is a sign-extended 32-bit value minus a constant, so 33 bits hold it
    assign a33     = s4_a_reg[32:0];
    assign aa_full = 66'(a33) * 66'(a33);

    assign pdiff = 21'd1048576 - {1'b0, s8_adcp_reg};

    always_comb begin
        v2 = s10_hv_reg - (s10_k_reg >>> 4);
        if (v2[31]) begin
            v2 = 32'sd0;
        end
        if (v2 > 32'sd419430400) begin
            v2 = 32'sd419430400;
        end
        hum_next = v2[28:12];
        inv_next = (s10_dv_reg == 64'sd0);
        num_next = s10_num_reg[63] ? 64'(-s10_num_reg) : 64'(s10_num_reg);
        if (inv_next) begin
            den_next = 64'd1;
        end else begin
            den_next = s10_dv_reg[63] ? 64'(-s10_dv_reg) : 64'(s10_dv_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_tap_reg   <= d1 * c.t2;
            s1_sq_reg    <= d2 * d2;
            s1_adcp_reg  <= in_p;
            s1_adch_reg  <= in_h;

            s2_ta_reg    <= s1_tap_reg >>> 11;
            s2_m2_reg    <= (s1_sq_reg >>> 12) * c.t3;
            s2_adcp_reg  <= s1_adcp_reg;
            s2_adch_reg  <= s1_adch_reg;

            s3_tfine_reg <= s2_ta_reg + (s2_m2_reg >>> 14);
            s3_adcp_reg  <= s2_adcp_reg;
            s3_adch_reg  <= s2_adch_reg;

            s4_temp_reg  <= t5 >>> 8;
            s4_a_reg     <= $signed({{32{s3_tfine_reg[31]}}, s3_tfine_reg}) - 64'sd128000;
            s4_v_reg     <= s3_tfine_reg - 32'sd76800;
            s4_adcp_reg  <= s3_adcp_reg;
            s4_adch_reg  <= s3_adch_reg;

            s5_aa_reg    <= aa_full[63:0];
            s5_ap5_reg   <= s4_a_reg * c.p5;
            s5_ap2_reg   <= s4_a_reg * c.p2;
            s5_h5v_reg   <= s4_v_reg * c.h5;
            s5_vh6_reg   <= s4_v_reg * c.h6;
            s5_vh3_reg   <= s4_v_reg * $signed({1'b0, c.h3});
            s5_temp_reg  <= s4_temp_reg;
            s5_adcp_reg  <= s4_adcp_reg;
            s5_adch_reg  <= s4_adch_reg;

            s6_b1_reg    <= s5_aa_reg * c.p6;
            s6_aa3_reg   <= s5_aa_reg * c.p3;
            s6_ap5_reg   <= s5_ap5_reg;
            s6_ap2_reg   <= s5_ap2_reg;
            s6_ha_reg    <= ($signed({2'd0, s5_adch_reg, 14'd0})
                             - $signed({c.h4[11:0], 20'd0})
                             - s5_h5v_reg + 32'sd16384) >>> 15;
            s6_hb1_reg   <= (s5_vh6_reg >>> 10) * ((s5_vh3_reg >>> 11) + 32'sd32768);
            s6_temp_reg  <= s5_temp_reg;
            s6_adcp_reg  <= s5_adcp_reg;

            s7_b_reg     <= s6_b1_reg + (s6_ap5_reg <<< 17)
                            + ($signed({{48{c.p4[15]}}, c.p4}) <<< 35);
            s7_a2_reg    <= (s6_aa3_reg >>> 8) + (s6_ap2_reg <<< 12);
            s7_hb2_reg   <= ((s6_hb1_reg >>> 10) + 32'sd2097152) * c.h2;
            s7_ha_reg    <= s6_ha_reg;
            s7_temp_reg  <= s6_temp_reg;
            s7_adcp_reg  <= s6_adcp_reg;

            s8_a3_reg    <= (64'sh0000_8000_0000_0000 + s7_a2_reg) * $signed({1'b0, c.p1});
            s8_b_reg     <= s7_b_reg;
            s8_hv_reg    <= s7_ha_reg * ((s7_hb2_reg + 32'sd8192) >>> 14);
            s8_temp_reg  <= s7_temp_reg;
            s8_adcp_reg  <= s7_adcp_reg;

            s9_dv_reg    <= s8_a3_reg >>> 33;
            s9_pn_reg    <= $signed({12'd0, pdiff, 31'd0}) - s8_b_reg;
            s9_ss_reg    <= (s8_hv_reg >>> 15) * (s8_hv_reg >>> 15);
            s9_hv_reg    <= s8_hv_reg;
            s9_temp_reg  <= s8_temp_reg;

            s10_num_reg  <= s9_pn_reg * 64'sd3125;
            s10_dv_reg   <= s9_dv_reg;
            s10_k_reg    <= (s9_ss_reg >>> 7) * $signed({1'b0, c.h1});
            s10_hv_reg   <= s9_hv_reg;
            s10_temp_reg <= s9_temp_reg;

            num_reg       <= num_next;
            den_reg       <= den_next;
            side_reg.temp <= s10_temp_reg;
            side_reg.hum  <= hum_next;
            side_reg.inv  <= inv_next;
            side_reg.qneg <= s10_num_reg[63] ^ s10_dv_reg[63];
        end
    end

    assign out_vld  = vld_reg[10];
    assign out_num  = num_reg;
    assign out_den  = den_reg;
    assign out_side = side_reg;

endmodule

### rtl/core/ecc_div.sv
// Pipelined unsigned restoring divider, one quotient bit per stage.
module ecc_div (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        en,
    input  logic                        in_vld,
    input  logic [ecc_pkg::DIV_W-1:0]   in_num,
    input  logic [ecc_pkg::DIV_W-1:0]   in_den,
    input  ecc_pkg::side_t              in_side,
    output logic                        out_vld,
    output logic [ecc_pkg::DIV_W-1:0]   out_quot,
    output ecc_pkg::side_t              out_side
);
    import ecc_pkg::*;

    logic [DIV_W-1:0] vld_reg;
    logic [DIV_W-1:0] num_reg  [DIV_W];
    side_t            side_reg [DIV_W];
    // last stage needs no remainder or divisor
    logic [DIV_W-1:0] rem_reg  [DIV_W-1];
    logic [DIV_W-1:0] den_reg  [DIV_W-1];

    for (genvar i = 0; i < DIV_W; i++) begin : g_stage
        logic [DIV_W-1:0] rem_in, num_in, den_in;
        side_t            side_in;
        logic             vld_in;
        logic [DIV_W:0]   trial, diff;
        logic             fit;

        if (i == 0) begin : g_first
            assign rem_in  = '0;
            assign num_in  = in_num;
            assign den_in  = in_den;
            assign side_in = in_side;
            assign vld_in  = in_vld;
        end else begin : g_rest
            assign rem_in  = rem_reg[i-1];
            assign num_in  = num_reg[i-1];
            assign den_in  = den_reg[i-1];
            assign side_in = side_reg[i-1];
            assign vld_in  = vld_reg[i-1];
        end

        assign trial = {rem_in, num_in[DIV_W-1]};
        assign diff  = trial - {1'b0, den_in};
        assign fit   = !diff[DIV_W];

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[i] <= 1'b0;
            end else if (en) begin
                vld_reg[i] <= vld_in;
            end
            if (en) begin
                num_reg[i]  <= {num_in[DIV_W-2:0], fit};
                side_reg[i] <= side_in;
            end
        end

        if (i < DIV_W - 1) begin : g_rem
            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[i] <= fit ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
                    den_reg[i] <= den_in;
                end
            end
        end
    end

    assign out_vld  = vld_reg[DIV_W-1];
    assign out_quot = num_reg[DIV_W-1];
    assign out_side = side_reg[DIV_W-1];

endmodule

### rtl/core/ecc_back.sv
// Back pipeline: quotient sign, second-order pressure terms and the result register.
module ecc_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_vld,
    input  logic [63:0]       in_quot,
    input  ecc_pkg::side_t    in_side,
    input  ecc_pkg::coef_t    c,
    output logic              out_vld,
    output ecc_pkg::res_t     out_res
);
    import ecc_pkg::*;

    logic [4:0] vld_reg;

    logic signed [63:0] b1_q_reg;
    side_t              b1_side_reg;
    logic signed [63:0] b2_q_reg, b2_q13_reg, b2_m1_reg, b2_pb_reg;
    side_t              b2_side_reg;
    logic signed [63:0] b3_q_reg, b3_pb_reg;
    logic [63:0]        b3_pplo_reg;
    logic [31:0]        b3_pphi_reg;
    side_t              b3_side_reg;
    logic signed [63:0] b4_q_reg, b4_a_reg, b4_b_reg;
    side_t              b4_side_reg;
    logic signed [63:0] p_next;
    res_t               res_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[3:0], in_vld};
        end
    end

    assign p_next = ((b4_q_reg + b4_a_reg + b4_b_reg) >>> 8)
                    + ($signed({{48{c.p7[15]}}, c.p7}) <<< 4);

    always_ff @(posedge aclk) begin
        if (en) begin
            b1_q_reg    <= in_side.qneg ? $signed(-in_quot) : $signed(in_quot);
            b1_side_reg <= in_side;

            b2_q_reg    <= b1_q_reg;
            b2_q13_reg  <= b1_q_reg >>> 13;
            b2_m1_reg   <= (b1_q_reg >>> 13) * c.p9;
            b2_pb_reg   <= b1_q_reg * c.p8;
            b2_side_reg <= b1_side_reg;

            // low 64 bits of m1 * q13 from 32-bit partial products
            b3_pplo_reg <= 64'(b2_m1_reg[31:0]) * 64'(b2_q13_reg[31:0]);
            b3_pphi_reg <= b2_m1_reg[31:0] * b2_q13_reg[63:32]
                           + b2_m1_reg[63:32] * b2_q13_reg[31:0];
            b3_q_reg    <= b2_q_reg;
            b3_pb_reg   <= b2_pb_reg;
            b3_side_reg <= b2_side_reg;

            b4_a_reg    <= $signed(b3_pplo_reg + {b3_pphi_reg, 32'd0}) >>> 25;
            b4_b_reg    <= b3_pb_reg >>> 19;
            b4_q_reg    <= b3_q_reg;
            b4_side_reg <= b3_side_reg;

            res_reg.temp  <= b4_side_reg.temp;
            res_reg.press <= b4_side_reg.inv ? 32'd0 : p_next[31:0];
            res_reg.inv   <= b4_side_reg.inv;
            res_reg.hum   <= b4_side_reg.hum;
        end
    end

    assign out_vld = vld_reg[4];
    assign out_res = res_reg;

endmodule
